@@ src/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg: shared types and constants of the control frame receiver
// Word layouts, register indexes and sizes used by the parser, the link
// monitor and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package cfr_pkg;

  // Largest data field of a frame (range 7 to 31)
  localparam int unsigned MaxPayload = 16;

  // Data bytes of a control frame: buttons, misc, dpad, lx, ly, rx, ry
  localparam int unsigned CtrlLen = 7;

  localparam int unsigned LenW   = 5;   // length and position counters
  localparam int unsigned TickW  = 17;  // elapsed tick counter
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TickW-1:0] TickMax = {TickW{1'b1}};

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgFirstHeader  = 2'd0,
    CfgSecondHeader = 2'd1,
    CfgControlType  = 2'd2,
    CfgTimeoutTicks = 2'd3
  } cfg_reg_e;

  localparam logic [7:0]  FirstHeaderRst  = 8'd170;
  localparam logic [7:0]  SecondHeaderRst = 8'd85;
  localparam logic [7:0]  ControlTypeRst  = 8'd1;
  localparam logic [15:0] TimeoutTicksRst = 16'd500;

  typedef logic [CtrlLen-1:0][7:0] ctrl_bytes_t;

  typedef struct packed {
    logic       mode;     // 0: serial byte, 1: millisecond tick
    logic [7:0] rx_byte;
  } in_item_t;

  typedef struct packed {
    logic              frame_accepted;
    logic              link_ok;
    logic [7:0]        buttons;
    logic [7:0]        misc_buttons;
    logic [7:0]        dpad;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
  } out_item_t;

  // Parser to link monitor: a control frame completed on this byte
  typedef struct packed {
    logic        load;
    ctrl_bytes_t data;
  } frame_evt_t;

endpackage

`default_nettype wire

@@ src/cfr_parser.sv @@
// ----------------------------------------------------------------------------
// cfr_parser: frame parser
// Hunts for the two header bytes, collects type, length, data and checksum,
// and flags a checked control frame of the expected type and length.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_parser #(
  parameter int unsigned MaxPayload = cfr_pkg::MaxPayload
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                byte_en_i,
  input  wire logic [7:0]          rx_byte_i,
  input  wire logic [7:0]          first_header_i,
  input  wire logic [7:0]          second_header_i,
  input  wire logic [7:0]          control_type_i,
  output cfr_pkg::frame_evt_t      evt_o
);

  localparam int unsigned IdxW = (MaxPayload > 1) ? $clog2(MaxPayload) : 1;
  localparam logic [7:0] MaxLenByte = 8'(MaxPayload);
  localparam logic [cfr_pkg::LenW-1:0] MaxPos = cfr_pkg::LenW'(MaxPayload);
  localparam logic [cfr_pkg::LenW-1:0] CtrlLenW = cfr_pkg::LenW'(cfr_pkg::CtrlLen);

  typedef enum logic [5:0] {
    PhHdr1 = 6'b000001,
    PhHdr2 = 6'b000010,
    PhType = 6'b000100,
    PhLen  = 6'b001000,
    PhData = 6'b010000,
    PhChk  = 6'b100000
  } phase_e;

  phase_e                      phase_q, phase_d;
  logic [7:0]                  kind_q, kind_d;
  logic [cfr_pkg::LenW-1:0]    len_q, len_d;
  logic [cfr_pkg::LenW-1:0]    pos_q, pos_d, pos_inc;
  logic [7:0]                  xor_q, xor_d;
  logic [7:0]                  store_q [MaxPayload];
  logic                        store_we;
  logic                        frame_ok;

  assign pos_inc = pos_q + 1'b1;

  always_comb begin
    phase_d  = phase_q;
    kind_d   = kind_q;
    len_d    = len_q;
    pos_d    = pos_q;
    xor_d    = xor_q;
    store_we = 1'b0;
    frame_ok = 1'b0;
    case (phase_q)
      PhHdr2: begin
        phase_d = (rx_byte_i == second_header_i) ? PhType : PhHdr1;
      end
      PhType: begin
        kind_d  = rx_byte_i;
        xor_d   = rx_byte_i;
        phase_d = PhLen;
      end
      PhLen: begin
        xor_d = xor_q ^ rx_byte_i;
        if (rx_byte_i > MaxLenByte) begin
          phase_d = PhHdr1;
        end else begin
          len_d   = rx_byte_i[cfr_pkg::LenW-1:0];
          pos_d   = '0;
          phase_d = (rx_byte_i == 8'd0) ? PhChk : PhData;
        end
      end
      PhData: begin
        store_we = (pos_q < MaxPos);
        xor_d    = xor_q ^ rx_byte_i;
        pos_d    = pos_inc;
        if (pos_inc >= len_q) begin
          phase_d = PhChk;
        end
      end
      PhChk: begin
        frame_ok = (rx_byte_i == xor_q) && (kind_q == control_type_i) &&
                   (len_q == CtrlLenW);
        phase_d  = PhHdr1;
      end
      default: begin
        xor_d   = '0;
        phase_d = (rx_byte_i == first_header_i) ? PhHdr2 : PhHdr1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHdr1;
      kind_q  <= '0;
      len_q   <= '0;
      pos_q   <= '0;
      xor_q   <= '0;
    end else if (byte_en_i) begin
      phase_q <= phase_d;
      kind_q  <= kind_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
      xor_q   <= xor_d;
    end
  end

  // Data bytes, valid only once written in the current frame
  always_ff @(posedge clk_i) begin
    if (byte_en_i && store_we) begin
      store_q[pos_q[IdxW-1:0]] <= rx_byte_i;
    end
  end

  always_comb begin
    evt_o.load = byte_en_i && frame_ok;
    for (int i = 0; i < int'(cfr_pkg::CtrlLen); i++) begin
      evt_o.data[i] = store_q[i];
    end
  end

endmodule

`default_nettype wire

@@ src/cfr_link.sv @@
// ----------------------------------------------------------------------------
// cfr_link: link monitor and control value holder
// Saturating millisecond counter, timeout compare, and the seven control
// bytes that a good frame loads and a lost link clears.
// ----------------------------------------------------------------------------
`default_nettype none

module cfr_link (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic                 tick_i,
  input  wire cfr_pkg::frame_evt_t  evt_i,
  input  wire logic [15:0]          timeout_ticks_i,
  output logic                      link_ok_o,
  output cfr_pkg::ctrl_bytes_t      ctrl_o
);

  logic [cfr_pkg::TickW-1:0] ticks_q, ticks_d;
  cfr_pkg::ctrl_bytes_t      ctrl_q, ctrl_d;
  logic                      link;

  always_comb begin
    ticks_d = ticks_q;
    if (tick_i) begin
      if (ticks_q != cfr_pkg::TickMax) begin
        ticks_d = ticks_q + 1'b1;
      end
    end else if (evt_i.load) begin
      ticks_d = '0;
    end
    link   = (ticks_d <= {1'b0, timeout_ticks_i});
    ctrl_d = evt_i.load ? evt_i.data : ctrl_q;
    if (!link) begin
      ctrl_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ticks_q <= '0;
      ctrl_q  <= '0;
    end else if (step_i) begin
      ticks_q <= ticks_d;
      ctrl_q  <= ctrl_d;
    end
  end

  assign link_ok_o = link;
  assign ctrl_o    = ctrl_d;

endmodule

`default_nettype wire

@@ src/control_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// control_frame_receiver: framed controller data receiver with link timeout
// Parses header, type, length, data and XOR checksum from serial bytes and
// keeps the latest control values while millisecond ticks stay in budget.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o, in_item_i) carries one word per
//   event: a received serial byte (mode 0) or a millisecond tick (mode 1).
//   Output channel (out_valid_o/out_ready_i, out_item_o) returns exactly one
//   word per input word, in order: frame_accepted, link_ok and the seven
//   control values (zero while the link is lost).
//   Config channel (cfg_valid_i/cfg_ready_o) writes headers, control type
//   and timeout by index; it is always ready. The user must write it only
//   while idle; the block itself does not enforce this. An accepted word
//   goes from the input register through one pass of parser logic into the
//   result register. Throughput: one word per clock while the output is not
//   stalled. When the receiver stalls, the result register holds and the input
//   register takes one more word; after that in_ready_o drops until the
//   result is taken.
//   Reset: parser hunts for the first header, controls are zero, tick
//   counter is zero, registers take their default values.
// ----------------------------------------------------------------------------
`default_nettype none

module control_frame_receiver #(
  parameter int unsigned MaxPayload = cfr_pkg::MaxPayload
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire cfr_pkg::in_item_t             in_item_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output cfr_pkg::out_item_t                 out_item_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [cfr_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [cfr_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [7:0]  first_header_q, second_header_q, control_type_q;
  logic [15:0] timeout_ticks_q;

  logic                 s1_valid_q;
  cfr_pkg::in_item_t    s1_item_q;
  logic                 out_valid_q;
  cfr_pkg::out_item_t   out_item_q, result;
  logic                 advance;

  cfr_pkg::frame_evt_t  evt;
  cfr_pkg::ctrl_bytes_t ctrl;
  logic                 link_ok;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_header_q  <= cfr_pkg::FirstHeaderRst;
      second_header_q <= cfr_pkg::SecondHeaderRst;
      control_type_q  <= cfr_pkg::ControlTypeRst;
      timeout_ticks_q <= cfr_pkg::TimeoutTicksRst;
    end else if (cfg_valid_i) begin
      case (cfr_pkg::cfg_reg_e'(cfg_index_i))
        cfr_pkg::CfgFirstHeader:  first_header_q  <= cfg_data_i[7:0];
        cfr_pkg::CfgSecondHeader: second_header_q <= cfg_data_i[7:0];
        cfr_pkg::CfgControlType:  control_type_q  <= cfg_data_i[7:0];
        cfr_pkg::CfgTimeoutTicks: timeout_ticks_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // The word in the input register is processed when the result slot frees
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
  end

  cfr_parser #(
    .MaxPayload(MaxPayload)
  ) u_parser (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .byte_en_i      (advance && !s1_item_q.mode),
    .rx_byte_i      (s1_item_q.rx_byte),
    .first_header_i (first_header_q),
    .second_header_i(second_header_q),
    .control_type_i (control_type_q),
    .evt_o          (evt)
  );

  cfr_link u_link (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .tick_i         (s1_item_q.mode),
    .evt_i          (evt),
    .timeout_ticks_i(timeout_ticks_q),
    .link_ok_o      (link_ok),
    .ctrl_o         (ctrl)
  );

  always_comb begin
    result.frame_accepted = evt.load;
    result.link_ok        = link_ok;
    result.buttons        = ctrl[0];
    result.misc_buttons   = ctrl[1];
    result.dpad           = ctrl[2];
    result.left_x         = ctrl[3];
    result.left_y         = ctrl[4];
    result.right_x        = ctrl[5];
    result.right_y        = ctrl[6];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

`default_nettype wire

@@ verif/control_frame_receiver_test.sv @@
// ----------------------------------------------------------------------------
// control_frame_receiver_test: self-checking bench for the frame receiver
// Feeds serial byte and tick events through the valid/ready input channel,
// predicts every status word with a behavioral parser and link timer, and
// checks each returned word in order. Runs a short directed set, then
// random frame traffic under several register settings and idle patterns,
// and finally a short tick run that drops the link and brings it back.
// ----------------------------------------------------------------------------
`default_nettype none

module control_frame_receiver_test;
  import cfr_pkg::*;

  localparam int unsigned StallLimit = 2000;  // cycles with no handshake at all
  localparam int unsigned DrainWait  = 8;

  typedef enum logic [2:0] {
    WaitHdr1, WaitHdr2, GetType, GetLen, GetData, GetSum
  } rx_phase_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  control_frame_receiver u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  // event words waiting to be sent, status words waiting to come back
  in_item_t  pending_events[$];
  out_item_t expected_status[$];

  int unsigned send_idle_pct = 21;
  int unsigned recv_idle_pct = 62;
  int unsigned tick_mix_pct  = 0;
  logic        in_taken = 1'b0;

  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  int unsigned n_events     = 0;
  int unsigned n_loaded     = 0;
  int unsigned n_link_down  = 0;

  // receiver copy: registers
  logic [7:0]  hdr1_val;
  logic [7:0]  hdr2_val;
  logic [7:0]  ctrl_type_val;
  logic [15:0] timeout_val;
  // receiver copy: parser and link timer
  rx_phase_e   rx_phase;
  logic [7:0]  rx_kind;
  logic [4:0]  rx_len;
  logic [4:0]  rx_pos;
  logic [7:0]  rx_sum;
  logic [7:0]  rx_store [MaxPayload];
  logic [7:0]  ctrl_vals [CtrlLen];
  logic [TickW-1:0] tick_count;

  logic [7:0] frame_buf [MaxPayload];

  initial begin
    forever #5 clk = ~clk;
  end

  // Status word for one event; advances the receiver copy.
  function automatic out_item_t parse_event(in_item_t ev);
    out_item_t  res;
    logic       loaded;
    logic [7:0] b;
    loaded = 1'b0;
    b = ev.rx_byte;
    if (ev.mode) begin
      if (tick_count != TickMax) tick_count = tick_count + 1'b1;
    end else begin
      case (rx_phase)
        WaitHdr2: rx_phase = (b == hdr2_val) ? GetType : WaitHdr1;
        GetType: begin
          rx_kind = b;
          rx_sum = b;
          rx_phase = GetLen;
        end
        GetLen: begin
          rx_sum = rx_sum ^ b;
          if (b > MaxPayload) begin
            rx_phase = WaitHdr1;
          end else begin
            rx_len = b[4:0];
            rx_pos = '0;
            rx_phase = (b == 8'd0) ? GetSum : GetData;
          end
        end
        GetData: begin
          if (rx_pos < MaxPayload) rx_store[rx_pos] = b;
          rx_sum = rx_sum ^ b;
          rx_pos = rx_pos + 5'd1;
          if (rx_pos >= rx_len) rx_phase = GetSum;
        end
        GetSum: begin
          if (b == rx_sum && rx_kind == ctrl_type_val && rx_len == CtrlLen) begin
            for (int i = 0; i < CtrlLen; i++) ctrl_vals[i] = rx_store[i];
            tick_count = '0;
            loaded = 1'b1;
          end
          rx_phase = WaitHdr1;
        end
        default: begin
          rx_sum = '0;
          rx_phase = (b == hdr1_val) ? WaitHdr2 : WaitHdr1;
        end
      endcase
    end
    res.frame_accepted = loaded;
    res.link_ok = (tick_count <= {1'b0, timeout_val});
    if (!res.link_ok) begin
      for (int i = 0; i < CtrlLen; i++) ctrl_vals[i] = '0;
    end
    res.buttons      = ctrl_vals[0];
    res.misc_buttons = ctrl_vals[1];
    res.dpad         = ctrl_vals[2];
    res.left_x       = ctrl_vals[3];
    res.left_y       = ctrl_vals[4];
    res.right_x      = ctrl_vals[5];
    res.right_y      = ctrl_vals[6];
    return res;
  endfunction

  function automatic string status_text(out_item_t s);
    return $sformatf("acc=%0b link=%0b btn=%02h misc=%02h dpad=%02h lx=%0d ly=%0d rx=%0d ry=%0d",
                     s.frame_accepted, s.link_ok, s.buttons, s.misc_buttons, s.dpad,
                     s.left_x, s.left_y, s.right_x, s.right_y);
  endfunction

  // Driver: new words go out on the falling edge.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (rst_n && pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_item <= pending_events.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: handshakes sampled on the rising edge.
  always @(posedge clk) begin
    out_item_t want;
    logic      any_fire;
    any_fire = 1'b0;
    in_taken = rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        any_fire = 1'b1;
        if (out_item.link_ok == 1'b0) n_link_down++;
        if (expected_status.size() == 0) begin
          if (mismatches < 10) $display("unexpected status word: %s", status_text(out_item));
          mismatches++;
        end else begin
          want = expected_status.pop_front();
          if (out_item.frame_accepted !== want.frame_accepted ||
              out_item.link_ok !== want.link_ok ||
              out_item.buttons !== want.buttons ||
              out_item.misc_buttons !== want.misc_buttons ||
              out_item.dpad !== want.dpad ||
              out_item.left_x !== want.left_x ||
              out_item.left_y !== want.left_y ||
              out_item.right_x !== want.right_x ||
              out_item.right_y !== want.right_y) begin
            if (mismatches < 10) begin
              $display("status mismatch: expected %s", status_text(want));
              $display("                 actual   %s", status_text(out_item));
            end
            mismatches++;
          end
        end
      end
      if (in_taken) begin
        any_fire = 1'b1;
        want = parse_event(in_item);
        if (want.frame_accepted) n_loaded++;
        n_events++;
        expected_status.push_back(want);
      end
      if (cfg_valid && cfg_ready) begin
        any_fire = 1'b1;
        case (cfg_reg_e'(cfg_index))
          CfgFirstHeader:  hdr1_val = cfg_data[7:0];
          CfgSecondHeader: hdr2_val = cfg_data[7:0];
          CfgControlType:  ctrl_type_val = cfg_data[7:0];
          CfgTimeoutTicks: timeout_val = cfg_data;
          default: ;
        endcase
      end
    end
    stall_cycles = any_fire ? 0 : stall_cycles + 1;
  end

  initial begin : watchdog
    while (stall_cycles < StallLimit) @(posedge clk);
    $display("no handshake for %0d cycles", StallLimit);
    $display("control_frame_receiver_test: done, errors");
    $finish;
  end

  task automatic add_tick();
    in_item_t ev;
    ev.mode = 1'b1;
    ev.rx_byte = 8'($urandom_range(255));
    pending_events.push_back(ev);
  endtask

  task automatic add_byte(input logic [7:0] b);
    in_item_t ev;
    if ($urandom_range(99) < tick_mix_pct) add_tick();
    ev.mode = 1'b0;
    ev.rx_byte = b;
    pending_events.push_back(ev);
  endtask

  // Header, type, length, frame_buf data and checksum (omitted when too long).
  task automatic add_frame(input logic [7:0] kind, input logic [7:0] len, input bit good_sum);
    logic [7:0] sum;
    logic [7:0] flip;
    flip = 8'($urandom_range(255, 1));
    add_byte(hdr1_val);
    add_byte(hdr2_val);
    add_byte(kind);
    add_byte(len);
    if (len <= MaxPayload) begin
      sum = kind ^ len;
      for (int k = 0; k < len; k++) begin
        add_byte(frame_buf[k]);
        sum = sum ^ frame_buf[k];
      end
      add_byte(good_sum ? sum : sum ^ flip);
    end
  endtask

  task automatic add_random_traffic(input int unsigned n_items);
    int unsigned start;
    int unsigned pick;
    int unsigned n;
    logic [7:0]  kind;
    logic [7:0]  len;
    start = pending_events.size();
    while (pending_events.size() - start < n_items) begin
      pick = $urandom_range(99);
      if (pick < 62) begin
        kind = ($urandom_range(99) < 75) ? ctrl_type_val : 8'($urandom_range(255));
        pick = $urandom_range(19);
        if (pick < 12) len = 8'(CtrlLen);
        else if (pick < 15) len = 8'($urandom_range(MaxPayload));
        else if (pick == 15) len = 8'd0;
        else if (pick == 16) len = 8'(MaxPayload);
        else len = 8'($urandom_range(255, MaxPayload + 1));
        for (int k = 0; k < MaxPayload; k++) frame_buf[k] = 8'($urandom_range(255));
        add_frame(kind, len, $urandom_range(99) < 85);
      end else if (pick < 78) begin
        n = ($urandom_range(3) == 0) ? $urandom_range(40, 1) : $urandom_range(3, 1);
        repeat (n) add_tick();
      end else if (pick < 90) begin
        add_byte(8'($urandom_range(255)));
      end else begin
        // first header followed by something that is probably not the second
        add_byte(hdr1_val);
        add_byte(8'($urandom_range(255)));
      end
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_events.size() != 0 || in_valid || expected_status.size() != 0);
  endtask

  task automatic set_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk);
    while (!cfg_ready);
  endtask

  // Unused upper data bits of the byte registers carry noise.
  task automatic program_regs(input logic [7:0] h1, input logic [7:0] h2,
                              input logic [7:0] ct, input logic [15:0] tmo);
    logic [7:0] noise;
    noise = 8'($urandom_range(255));
    set_reg(CfgFirstHeader, {noise, h1});
    set_reg(CfgSecondHeader, {~noise, h2});
    set_reg(CfgControlType, {noise ^ 8'h5a, ct});
    set_reg(CfgTimeoutTicks, tmo);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    hdr1_val = FirstHeaderRst;
    hdr2_val = SecondHeaderRst;
    ctrl_type_val = ControlTypeRst;
    timeout_val = TimeoutTicksRst;
    rx_phase = WaitHdr1;
    rx_kind = '0;
    rx_len = '0;
    rx_pos = '0;
    rx_sum = '0;
    tick_count = '0;
    for (int i = 0; i < MaxPayload; i++) rx_store[i] = '0;
    for (int i = 0; i < CtrlLen; i++) ctrl_vals[i] = '0;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset register values
    frame_buf[0] = 8'hff; frame_buf[1] = 8'h00; frame_buf[2] = 8'h80;
    frame_buf[3] = 8'h7f; frame_buf[4] = 8'h01; frame_buf[5] = 8'hfe;
    frame_buf[6] = 8'h55;
    add_frame(ctrl_type_val, 8'(CtrlLen), 1'b1);
    // zero length control-type frame with a tick in the middle: parsed, not loaded
    add_byte(hdr1_val);
    add_tick();
    add_byte(hdr2_val);
    add_byte(ctrl_type_val);
    add_byte(8'd0);
    add_byte(ctrl_type_val);
    add_byte(hdr1_val);
    add_byte(8'h12);
    add_frame(ctrl_type_val, 8'(MaxPayload + 1), 1'b1);
    add_frame(ctrl_type_val, 8'd0, 1'b0);
    wait_idle();

    tick_mix_pct = 8;
    program_regs(8'h00, 8'hff, 8'hff, 16'd0);
    add_random_traffic(140);
    wait_idle();

    send_idle_pct = 62;
    recv_idle_pct = 21;
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 16'($urandom_range(20, 3)));
    add_random_traffic(170);
    // make sure the link is down before the timeout is raised
    repeat (timeout_val + 2) add_tick();
    wait_idle();

    program_regs(8'hff, 8'h00, 8'h00, 16'hffff);
    add_random_traffic(140);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 16'($urandom_range(30)));
    add_random_traffic(170);
    wait_idle();

    // short tick run: link drops past the timeout, a new control frame restores it
    tick_mix_pct = 0;
    program_regs(FirstHeaderRst, SecondHeaderRst, ControlTypeRst, 16'd4);
    for (int k = 0; k < CtrlLen; k++) frame_buf[k] = 8'($urandom_range(255));
    add_frame(ctrl_type_val, 8'(CtrlLen), 1'b1);
    repeat (8) add_tick();
    add_frame(ctrl_type_val, 8'(CtrlLen), 1'b1);
    repeat (3) add_tick();
    wait_idle();

    repeat (DrainWait) @(posedge clk);
    mismatches += expected_status.size();
    $display("covered %0d events under 6 register settings, %0d control frames loaded,",
             n_events, n_loaded);
    $display("%0d words with link down, ending with a timeout drop and recovery",
             n_link_down);
    if (mismatches == 0) begin
      $display("control_frame_receiver_test: done, clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("control_frame_receiver_test: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
